>>> rtl/gpht_pkg.sv
package gpht_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int GROUP_WIDTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int CMD_W    = 2;
    localparam int HASH_W   = 64;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int OCC_W    = 11;
    localparam int TAG_BITS = 7;

    localparam logic [7:0] CTRL_EMPTY     = 8'hFF;
    localparam logic [7:0] CTRL_DELETED   = 8'h80;
    localparam logic [7:0] CTRL_CONST_BIT = 8'h80;
    localparam logic [7:0] TAG_MASK       = 8'h7F;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [HASH_W-1:0]  hash;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  read_value;
        logic [OCC_W-1:0]    occupancy;
    } t_rsp;

endpackage

>>> rtl/gpht_if.sv
interface gpht_req_if
    import gpht_pkg::*;
();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gpht_rsp_if
    import gpht_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/gpht_ram.sv
module gpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/group_probed_hash_table_top.sv
// Group-probed open-addressed hash table.
// Request channel i_req carries cmd (lookup, insert/update, erase), a 64-bit
// hash, a key and a value; response channel o_rsp returns status, slot,
// read_value and occupancy, one response per request, in order.
// One request is in work at a time: i_req.ready is high only while the
// sequencer is idle and the response register is free, so the next request
// is taken the cycle after the response transfers.
// Control bytes live in a RAM with a registered read and are walked one byte
// at a time through its single read port; key and value stores are separate RAMs.
// Per probe window the sequencer makes a tag pass and, if no key matches, a
// free-slot pass, each a read state and a check state per control byte; each
// tag match adds a key read and compare, and a decision state ends the search.
// Erase adds a neighbor-empty scan, and a new insert or an erase ends with two
// writes: the control byte and its mirror copy.
// After reset a clearing pass writes the empty marker into every control byte
// (all CAPACITY+GROUP_WIDTH of them) before the first request is taken.
// A stalled receiver holds the response; no new request is taken until the
// response transfers.
module group_probed_hash_table_top
    import gpht_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int GROUP_WIDTH = GROUP_WIDTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gpht_req_if.sink   i_req,
    gpht_rsp_if.source o_rsp
);
    localparam int SW      = $clog2(CAPACITY);
    localparam int CDEPTH  = CAPACITY + GROUP_WIDTH;
    localparam int CW      = $clog2(CDEPTH);
    localparam int GW      = $clog2(GROUP_WIDTH + 1);
    localparam int NG      = CAPACITY / GROUP_WIDTH;
    localparam int NGW     = $clog2(NG + 1);
    localparam int FREE_W  = $clog2(CAPACITY + 1);
    localparam logic [FREE_W-1:0] FREE_INIT = FREE_W'((CAPACITY / 8) * 7);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_TAGRD  = 11'b00000000100,
        S_TAGCK  = 11'b00000001000,
        S_KEYCK  = 11'b00000010000,
        S_FREERD = 11'b00000100000,
        S_FREECK = 11'b00001000000,
        S_DECIDE = 11'b00010000000,
        S_RUNRD  = 11'b00100000000,
        S_RUNCK  = 11'b01000000000,
        S_WRITE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [CMD_W-1:0]      r_cmd;
    logic [6:0]            r_tag;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [SW-1:0]         r_pos, n_pos;
    logic [SW-1:0]         r_stride, n_stride;
    logic [GW-1:0]         r_j, n_j;
    logic [NGW-1:0]        r_grp, n_grp;
    logic                  r_any_empty, n_any_empty;
    logic                  r_fseen, n_fseen;
    logic [SW-1:0]         r_fslot, n_fslot;
    logic                  r_found, n_found;
    logic [SW-1:0]         r_hit, n_hit;
    logic                  r_kwait, n_kwait;
    logic                  r_runphase, n_runphase;
    logic [GW-1:0]         r_run, n_run;
    logic [GW:0]           r_runsum, n_runsum;
    logic                  r_wr2, n_wr2;
    logic [CW-1:0]         r_clr, n_clr;
    logic [OCC_W-1:0]      r_live, n_live;
    logic [FREE_W-1:0]     r_free, n_free;
    logic                  r_ovalid, n_ovalid;
    t_rsp                  r_rsp, n_rsp;

    // control RAM
    logic          c_we;
    logic [CW-1:0] c_waddr, c_raddr;
    logic [7:0]    c_wdata, c_rdata;
    // key and value RAMs
    logic                  kv_we;
    logic [SW-1:0]         kv_waddr, kv_raddr;
    logic [KEY_BITS-1:0]   k_rdata;
    logic [VALUE_BITS-1:0] v_rdata;
    logic                  v_we;

    gpht_ram #(.WIDTH(8), .DEPTH(CDEPTH)) u_ctrl (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata));
    gpht_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(kv_waddr), .i_wdata(r_key),
        .i_raddr(kv_raddr), .o_rdata(k_rdata));
    gpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(kv_waddr), .i_wdata(r_val),
        .i_raddr(kv_raddr), .o_rdata(v_rdata));

    logic [CW-1:0] win_addr;
    logic [SW-1:0] win_slot;
    logic [SW-1:0] before_base;
    logic [SW-1:0] mirror_slot;
    logic [7:0]    wr_byte;

    assign win_addr    = CW'(r_pos) + CW'(r_j);
    assign win_slot    = r_pos + SW'(r_j);
    assign before_base = r_hit - SW'(GROUP_WIDTH);
    assign mirror_slot = r_fslot - SW'(GROUP_WIDTH);

    assign i_req.ready   = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_rsp;

    always_comb begin
        n_state = r_state; n_pos = r_pos; n_stride = r_stride; n_j = r_j;
        n_grp = r_grp; n_any_empty = r_any_empty; n_fseen = r_fseen;
        n_fslot = r_fslot; n_found = r_found; n_hit = r_hit; n_kwait = r_kwait;
        n_runphase = r_runphase; n_run = r_run; n_runsum = r_runsum;
        n_wr2 = r_wr2; n_clr = r_clr; n_live = r_live; n_free = r_free;
        n_ovalid = r_ovalid; n_rsp = r_rsp;
        c_we = 1'b0; c_waddr = r_clr; c_wdata = CTRL_EMPTY; c_raddr = win_addr;
        kv_we = 1'b0; v_we = 1'b0; kv_waddr = r_fslot; kv_raddr = win_slot;
        wr_byte = {1'b0, r_tag};
        if (o_rsp.valid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                c_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == CW'(CDEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_pos = i_req.payload.hash[SW-1:0];
                    n_stride = '0; n_j = '0; n_grp = '0;
                    n_fseen = 1'b0; n_fslot = '0; n_found = 1'b0;
                    n_state = S_TAGRD;
                end
            end
            S_TAGRD: begin
                n_state = S_TAGCK;
            end
            S_TAGCK: begin
                if (c_rdata == {1'b0, r_tag}) begin
                    kv_raddr = win_slot;
                    n_kwait = 1'b1;
                    n_state = S_KEYCK;
                end else if (r_j == GW'(GROUP_WIDTH - 1)) begin
                    n_j = '0; n_any_empty = 1'b0; n_state = S_FREERD;
                end else begin
                    n_j = r_j + 1'b1; n_state = S_TAGRD;
                end
            end
            S_KEYCK: begin
                // wait out the registered key read, then compare
                if (r_kwait) begin
                    n_kwait = 1'b0;
                end else if (k_rdata == r_key) begin
                    n_found = 1'b1; n_hit = win_slot;
                    kv_raddr = win_slot;
                    n_state = S_DECIDE;
                end else if (r_j == GW'(GROUP_WIDTH - 1)) begin
                    n_j = '0; n_any_empty = 1'b0; n_state = S_FREERD;
                end else begin
                    n_j = r_j + 1'b1; n_state = S_TAGRD;
                end
                if (r_kwait) kv_raddr = win_slot;
            end
            S_FREERD: begin
                n_state = S_FREECK;
            end
            S_FREECK: begin
                if ((c_rdata & CTRL_CONST_BIT) != 8'h00 && !r_fseen) begin
                    n_fseen = 1'b1; n_fslot = win_slot;
                end
                if (c_rdata == CTRL_EMPTY) begin
                    n_any_empty = 1'b1;
                end
                if (r_j == GW'(GROUP_WIDTH - 1)) begin
                    n_j = '0;
                    if (n_any_empty || r_grp == NGW'(NG - 1)) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_grp = r_grp + 1'b1;
                        n_stride = r_stride + SW'(GROUP_WIDTH);
                        n_pos = r_pos + r_stride + SW'(GROUP_WIDTH);
                        n_state = S_TAGRD;
                    end
                end else begin
                    n_j = r_j + 1'b1; n_state = S_FREERD;
                end
            end
            S_DECIDE: begin
                // value at hit is on v_rdata (read issued on the hit cycle)
                n_rsp.occupancy = r_live;
                n_rsp.slot = '0; n_rsp.read_value = '0; n_rsp.status = ST_ABSENT;
                n_wr2 = 1'b0;
                if (r_found) begin
                    n_rsp.slot = SLOT_W'(r_hit);
                    n_rsp.read_value = VALUE_W'(v_rdata);
                    n_rsp.status = ST_HIT;
                end
                if (r_cmd == CMD_INSERT) begin
                    if (r_found) begin
                        kv_waddr = r_hit; v_we = 1'b1;
                        n_rsp.read_value = VALUE_W'(r_val);
                        n_ovalid = 1'b1; n_state = S_IDLE;
                    end else if (r_free == '0 || !r_fseen) begin
                        n_rsp.status = ST_FULL;
                        n_ovalid = 1'b1; n_state = S_IDLE;
                    end else begin
                        // read fslot byte to see if it was empty
                        c_raddr = CW'(r_fslot);
                        n_rsp.status = ST_NEW; n_rsp.slot = SLOT_W'(r_fslot);
                        n_rsp.read_value = VALUE_W'(r_val);
                        n_state = S_WRITE;
                    end
                end else if (r_cmd == CMD_ERASE && r_found) begin
                    n_runphase = 1'b0; n_run = '0; n_runsum = '0;
                    n_state = S_RUNRD;
                end else begin
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            S_RUNRD: begin
                if (!r_runphase) begin
                    c_raddr = CW'(before_base) + CW'(GROUP_WIDTH - 1) - CW'(r_run);
                end else begin
                    c_raddr = CW'(r_hit) + CW'(r_run);
                end
                n_state = S_RUNCK;
            end
            S_RUNCK: begin
                if (c_rdata != CTRL_EMPTY && r_run != GW'(GROUP_WIDTH)) begin
                    n_run = r_run + 1'b1;
                end
                if (c_rdata == CTRL_EMPTY || r_run == GW'(GROUP_WIDTH - 1)
                        || r_run == GW'(GROUP_WIDTH)) begin
                    n_runsum = r_runsum + (GW+1)'(n_run);
                    n_run = '0;
                    if (r_runphase) begin
                        n_fslot = r_hit;
                        n_state = S_WRITE;
                    end else begin
                        n_runphase = 1'b1; n_state = S_RUNRD;
                    end
                end else begin
                    n_state = S_RUNRD;
                end
            end
            S_WRITE: begin
                if (r_cmd == CMD_ERASE) begin
                    wr_byte = (r_runsum >= (GW+1)'(GROUP_WIDTH)) ? CTRL_DELETED
                                                                 : CTRL_EMPTY;
                end
                c_we = 1'b1;
                if (!r_wr2) begin
                    c_waddr = CW'(r_fslot);
                    c_wdata = wr_byte;
                    n_wr2 = 1'b1;
                    if (r_cmd == CMD_ERASE) begin
                        if (wr_byte == CTRL_EMPTY && r_free < FREE_W'(CAPACITY)) begin
                            n_free = r_free + 1'b1;
                        end
                        if (r_live != '0) n_live = r_live - 1'b1;
                    end else begin
                        if (c_rdata == CTRL_EMPTY && r_free != '0) begin
                            n_free = r_free - 1'b1;
                        end
                        if (r_live < OCC_W'(CAPACITY)) n_live = r_live + 1'b1;
                        kv_we = 1'b1; v_we = 1'b1; kv_waddr = r_fslot;
                    end
                end else begin
                    // mirror copy of the byte
                    c_waddr = CW'(mirror_slot) + CW'(GROUP_WIDTH);
                    c_wdata = wr_byte;
                    n_rsp.occupancy = r_live;
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_live <= '0; r_free <= FREE_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_live <= n_live; r_free <= n_free;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd <= i_req.payload.cmd;
            r_tag <= i_req.payload.hash[HASH_W-1 -: TAG_BITS];
            r_key <= i_req.payload.key[KEY_BITS-1:0];
            r_val <= i_req.payload.value[VALUE_BITS-1:0];
        end
        r_pos <= n_pos; r_stride <= n_stride; r_j <= n_j; r_grp <= n_grp;
        r_any_empty <= n_any_empty; r_fseen <= n_fseen; r_fslot <= n_fslot;
        r_found <= n_found; r_hit <= n_hit; r_kwait <= n_kwait;
        r_runphase <= n_runphase; r_run <= n_run; r_runsum <= n_runsum;
        r_wr2 <= n_wr2; r_rsp <= n_rsp;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("ready while busy");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_rsp.ready) |=> (r_ovalid && $stable(r_rsp)))
        else $error("response dropped");
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= OCC_W'(CAPACITY)) else $error("occupancy overflow");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FREE_W'(CAPACITY)) else $error("free count overflow");
`endif
endmodule

>>> sim/tb_group_probed_hash_table_top.sv
module tb_group_probed_hash_table_top;
    import gpht_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int GW        = GROUP_WIDTH_DEF;
    localparam int CTRL_N    = CAP + GW;
    localparam int N_WINDOWS = CAP / GW;
    localparam int POOL_N    = 48;
    localparam int IDLE_MAX  = 20000;

    logic i_clk;
    logic i_rst_n;
    logic rst_done;

    gpht_req_if req_ch ();
    gpht_rsp_if rsp_ch ();

    group_probed_hash_table_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // shadow copy of the table
    logic [7:0]         ctrl_mem [CTRL_N];
    logic [KEY_W-1:0]   key_mem  [CAP];
    logic [VALUE_W-1:0] val_mem  [CAP];
    int                 live_entries;
    int                 empty_budget;

    t_rsp pending_rsp[$];
    int   n_errors;
    int   idle_cycles;
    int   stall_left;
    bit   no_gaps;

    logic [KEY_W-1:0]  pool_key  [POOL_N];
    logic [HASH_W-1:0] pool_hash [POOL_N];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic void clear_shadow();
        for (int i = 0; i < CTRL_N; i++) ctrl_mem[i] = CTRL_EMPTY;
        for (int i = 0; i < CAP; i++) begin
            key_mem[i] = '0;
            val_mem[i] = '0;
        end
        live_entries = 0;
        empty_budget = CAP / 8 * 7;
    endfunction

    function automatic void set_ctrl(int s, logic [7:0] b);
        ctrl_mem[s] = b;
        ctrl_mem[((s - GW) & (CAP - 1)) + GW] = b;
    endfunction

    function automatic t_rsp table_update(t_req r);
        t_rsp       res;
        logic [7:0] tag;
        int         pos;
        int         stride;
        int         hit;
        int         free_slot;
        bit         found;
        bit         free_seen;
        bit         any_empty;
        int         prev_base;
        int         run_b;
        int         run_a;
        tag       = {1'b0, r.hash[63:57]};
        pos       = int'(r.hash[9:0]);
        stride    = 0;
        found     = 0;
        free_seen = 0;
        free_slot = 0;
        hit       = 0;
        for (int n = 0; n < N_WINDOWS && !found; n++) begin
            any_empty = 0;
            for (int j = 0; j < GW && !found; j++) begin
                if (ctrl_mem[pos + j] == tag && key_mem[(pos + j) & (CAP - 1)] == r.key) begin
                    found = 1;
                    hit   = (pos + j) & (CAP - 1);
                end
            end
            if (!found) begin
                for (int j = 0; j < GW; j++) begin
                    if (ctrl_mem[pos + j][7] && !free_seen) begin
                        free_seen = 1;
                        free_slot = (pos + j) & (CAP - 1);
                    end
                    if (ctrl_mem[pos + j] == CTRL_EMPTY) any_empty = 1;
                end
                if (any_empty) break;
                stride += GW;
                pos = (pos + stride) & (CAP - 1);
            end
        end
        res.status     = ST_ABSENT;
        res.slot       = '0;
        res.read_value = '0;
        if (r.cmd == CMD_INSERT) begin
            if (found) begin
                val_mem[hit]   = r.value;
                res.status     = ST_HIT;
                res.slot       = hit[SLOT_W-1:0];
                res.read_value = r.value;
            end else if (empty_budget == 0 || !free_seen) begin
                res.status = ST_FULL;
            end else begin
                if (ctrl_mem[free_slot] == CTRL_EMPTY) empty_budget--;
                if (live_entries < CAP) live_entries++;
                set_ctrl(free_slot, tag);
                key_mem[free_slot] = r.key;
                val_mem[free_slot] = r.value;
                res.status     = ST_NEW;
                res.slot       = free_slot[SLOT_W-1:0];
                res.read_value = r.value;
            end
        end else if (r.cmd == CMD_ERASE) begin
            if (found) begin
                prev_base = (hit - GW) & (CAP - 1);
                run_b  = 0;
                run_a  = 0;
                while (run_b < GW && ctrl_mem[prev_base + GW - 1 - run_b] != CTRL_EMPTY)
                    run_b++;
                while (run_a < GW && ctrl_mem[hit + run_a] != CTRL_EMPTY) run_a++;
                if (run_b + run_a >= GW) begin
                    set_ctrl(hit, CTRL_DELETED);
                end else begin
                    set_ctrl(hit, CTRL_EMPTY);
                    if (empty_budget < CAP) empty_budget++;
                end
                if (live_entries > 0) live_entries--;
                res.status     = ST_HIT;
                res.slot       = hit[SLOT_W-1:0];
                res.read_value = val_mem[hit];
            end
        end else if (found) begin
            // lookup, and the unused command behaves the same
            res.status     = ST_HIT;
            res.slot       = hit[SLOT_W-1:0];
            res.read_value = val_mem[hit];
        end
        res.occupancy = live_entries[OCC_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        if (no_gaps) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
        $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
        n_errors++;
    endtask

    // hold valid high across back-to-back transfers; lower it only for a gap
    task automatic send_req(logic [CMD_W-1:0] c, logic [HASH_W-1:0] h,
                            logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                            output logic [STATUS_W-1:0] st);
        t_req r;
        t_rsp e;
        int   gap;
        r.cmd   = c;
        r.hash  = h;
        r.key   = k;
        r.value = v;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        e = table_update(r);
        pending_rsp.push_back(e);
        st = e.status;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [HASH_W-1:0] rand_hash();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed();
        logic [STATUS_W-1:0] st;
        logic [HASH_W-1:0]   h;
        send_req(CMD_UNUSED, 64'h0, 32'h0, 32'h0, st);
        send_req(CMD_LOOKUP, '1, '1, '1, st);
        send_req(CMD_ERASE, '1, '1, '0, st);
        send_req(CMD_INSERT, '1, '1, '1, st);
        send_req(CMD_INSERT, 64'h0, 32'h0, 32'h0, st);
        send_req(CMD_LOOKUP, '1, '1, '0, st);
        send_req(CMD_UNUSED, 64'h0, 32'h0, 32'h5, st);
        send_req(CMD_INSERT, '1, '1, 32'h1234_5678, st);
        send_req(CMD_ERASE, 64'h0, 32'h0, '1, st);
        send_req(CMD_LOOKUP, 64'h0, 32'h0, '0, st);
        // pile keys on one home slot near the end so windows wrap and overflow
        h = 64'hA5A5_0000_0000_03FC;
        for (int i = 0; i < 18; i++) send_req(CMD_INSERT, h, 32'h100 + i, 32'hC000 + i, st);
        send_req(CMD_LOOKUP, h, 32'h111, '0, st);
        send_req(CMD_ERASE, h, 32'h104, '0, st);
        send_req(CMD_ERASE, h, 32'h111, '0, st);
        send_req(CMD_INSERT, h, 32'h200, 32'hBEEF, st);
    endtask

    task automatic test_pool_random(int n_items);
        logic [STATUS_W-1:0] st;
        logic [CMD_W-1:0]    c;
        int                  idx;
        int                  homes[3];
        homes = '{1016, 5, 500};
        for (int i = 0; i < POOL_N; i++) begin
            pool_key[i]        = $urandom;
            pool_hash[i]       = rand_hash();
            pool_hash[i][9:0]  = 10'(homes[i % 3] + $urandom_range(0, 3));
            if (i % 8 == 0) pool_hash[i][63:57] = pool_hash[0][63:57];
        end
        for (int i = 0; i < n_items; i++) begin
            if (i % 60 == 0) no_gaps = ~no_gaps;
            c = CMD_W'($urandom_range(0, 9) < 4 ? CMD_INSERT : $urandom_range(0, 3));
            if ($urandom_range(0, 99) < 15) begin
                send_req(CMD_W'($urandom), rand_hash(), $urandom, $urandom, st);
            end else begin
                idx = $urandom_range(0, POOL_N - 1);
                send_req(c, pool_hash[idx], pool_key[idx], $urandom, st);
            end
        end
        no_gaps = 0;
    endtask

    // stall the receiver in runs: mostly short, now and then long
    always @(negedge i_clk) begin
        if (no_gaps) begin
            rsp_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left   <= pick_gap();
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rsp e;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", 64'(0), 64'(rsp_ch.payload));
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_ch.payload.status !== e.status)
                    report_mismatch("status", 64'(e.status), 64'(rsp_ch.payload.status));
                if (rsp_ch.payload.slot !== e.slot)
                    report_mismatch("slot", 64'(e.slot), 64'(rsp_ch.payload.slot));
                if (rsp_ch.payload.read_value !== e.read_value)
                    report_mismatch("read_value", 64'(e.read_value),
                                    64'(rsp_ch.payload.read_value));
                if (rsp_ch.payload.occupancy !== e.occupancy)
                    report_mismatch("occupancy", 64'(e.occupancy),
                                    64'(rsp_ch.payload.occupancy));
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_done) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        rst_done       = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        n_errors       = 0;
        idle_cycles    = 0;
        stall_left     = 0;
        no_gaps        = 0;
        clear_shadow();
        repeat (3) @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;
        test_directed();
        test_pool_random(360);
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && pending_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
